// File: hw/rtl/ear_pkg.sv
// Shared types and constants for the extended sequence number anti-replay window.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ear_pkg;

	localparam int SEQ_W  = 32;
	localparam int TOP_W  = 64;
	localparam int WORD_W = 32;
	localparam int OFF_W  = 5;

	typedef enum logic {
		ACT_CHECK  = 1'b0,
		ACT_RECORD = 1'b1
	} action_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic sweep_rd;
		logic init_wr;
		logic ld_chk;
		logic ld_rec;
	} ear_cmd_t;

	typedef struct packed {
		logic init_last;
		logic sweep_last;
		logic out_free;
	} ear_sts_t;

endpackage

// File: hw/rtl/ear_req_if.sv
// Request channel: valid/ready handshake with the action and sequence number halves.
// Depends on ear_pkg for field widths.
interface ear_req_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [ear_pkg::SEQ_W-1:0]  seq_low;
	logic [ear_pkg::SEQ_W-1:0]  seq_high;

	modport source (output valid, output action, output seq_low, output seq_high, input ready);
	modport sink   (input valid, input action, input seq_low, input seq_high, output ready);
endinterface

// File: hw/rtl/ear_rsp_if.sv
// Response channel: valid/ready handshake with the replay flag, inferred high half and top.
// Depends on ear_pkg for field widths.
interface ear_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       replay;
	logic [ear_pkg::SEQ_W-1:0]  inferred_high;
	logic [ear_pkg::TOP_W-1:0]  top_seq;

	modport source (output valid, output replay, output inferred_high, output top_seq, input ready);
	modport sink   (input valid, input replay, input inferred_high, input top_seq, output ready);
endinterface

// File: hw/rtl/ear_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module ear_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: hw/rtl/ear_ctrl.sv
// Controller state machine for the anti-replay window.
// Depends on ear_pkg for the command and status structs and the action codes.
module ear_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ear_pkg::action_t  in_action,
	output logic              in_ready,
	input  ear_pkg::ear_sts_t sts,
	output ear_pkg::ear_cmd_t cmd
);
	import ear_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CHK,
		S_PREP,
		S_SWEEP,
		S_DRAIN,
		S_REC_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (sts.init_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_action == ACT_RECORD) ? S_PREP : S_CHK;
					end
				end
				S_CHK: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				S_PREP: begin
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (sts.sweep_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_REC_OUT;
				end
				S_REC_OUT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign cmd.accept   = (state_q == S_IDLE) && in_valid;
	assign cmd.prep     = (state_q == S_PREP);
	assign cmd.sweep_rd = (state_q == S_SWEEP);
	assign cmd.init_wr  = (state_q == S_INIT);
	assign cmd.ld_chk   = (state_q == S_CHK) && sts.out_free;
	assign cmd.ld_rec   = (state_q == S_REC_OUT) && sts.out_free;

	a_accept_branch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_CHK || state_q == S_PREP))
		else $error("accepted transaction did not enter a work state");

	a_rec_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REC_OUT) |-> ($past(state_q) == S_DRAIN || $past(state_q) == S_REC_OUT))
		else $error("record result reached without finishing the ring writes");

	a_chk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && !sts.out_free) |=> (state_q == S_CHK))
		else $error("check result dropped while the output register was full");
endmodule

// File: hw/rtl/ear_dp.sv
// Datapath for the anti-replay window: top register, seen-bit ring RAM, sweep and output register.
// Depends on ear_pkg, ear_ram and the response channel interface.
module ear_dp #(
	parameter int WINDOW_BITS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ear_pkg::ear_cmd_t          cmd,
	output ear_pkg::ear_sts_t          sts,
	input  logic [ear_pkg::SEQ_W-1:0]  seq_low,
	input  logic [ear_pkg::SEQ_W-1:0]  seq_high,
	ear_rsp_if.source                  rsp
);
	import ear_pkg::*;

	localparam int IDXW = $clog2(WINDOW_BITS);
	localparam int NW   = WINDOW_BITS / WORD_W;
	localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
	localparam int NWW  = AW + 1;
	localparam logic [AW-1:0] AMASK = AW'(NW - 1);

	logic [SEQ_W-1:0]  lo_q;
	logic [SEQ_W-1:0]  hi_in_q;
	logic [TOP_W-1:0]  top_q;
	logic [IDXW-1:0]   start_q;
	logic [IDXW:0]     cnt_q;
	logic [NWW-1:0]    nwords_q;
	logic [NWW-1:0]    k_q;
	logic [AW-1:0]     init_q;
	logic              wr_pend_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic              out_valid_q;
	logic              replay_q;
	logic [SEQ_W-1:0]  ihigh_q;
	logic [TOP_W-1:0]  top_out_q;

	logic [IDXW-1:0]   fidx;
	logic [TOP_W-1:0]  rec_full;
	logic              rec_gt;
	logic [TOP_W-1:0]  rec_gap;
	logic [IDXW:0]     cnt_d;
	logic [IDXW-1:0]   start_d;
	logic [IDXW:0]     span_d;
	logic [IDXW:0]     nw_raw;
	logic [NWW-1:0]    nwords_d;

	logic [SEQ_W-1:0]  chk_tl;
	logic [SEQ_W-1:0]  chk_th;
	logic [SEQ_W-1:0]  chk_bound;
	logic              chk_ge;
	logic [SEQ_W-1:0]  chk_hi;
	logic              chk_le;
	logic              chk_bit;

	logic [AW-1:0]     sweep_addr;
	logic [AW-1:0]     chk_addr;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] clr_mask;
	logic [WORD_W-1:0] set_mask;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic              out_free;

	assign fidx = lo_q[IDXW-1:0];

	assign rec_full = {hi_in_q, lo_q};
	assign rec_gt   = rec_full > top_q;
	assign rec_gap  = rec_full - top_q;

	always_comb begin
		if (!rec_gt) begin
			cnt_d = '0;
		end else if (rec_gap[TOP_W-1:IDXW] != '0) begin
			cnt_d = (IDXW+1)'(WINDOW_BITS);
		end else begin
			cnt_d = {1'b0, rec_gap[IDXW-1:0]};
		end
		if (cnt_d == '0) begin
			start_d = fidx;
		end else begin
			start_d = fidx - cnt_d[IDXW-1:0] + IDXW'(1);
		end
		span_d = (IDXW+1)'(start_d[OFF_W-1:0]) + cnt_d - (IDXW+1)'(1);
		nw_raw = (span_d >> OFF_W) + (IDXW+1)'(1);
		if (cnt_d == '0) begin
			nwords_d = NWW'(1);
		end else if (nw_raw > (IDXW+1)'(NW)) begin
			nwords_d = NWW'(NW);
		end else begin
			nwords_d = NWW'(nw_raw);
		end
	end

	assign chk_tl    = top_q[SEQ_W-1:0];
	assign chk_th    = top_q[TOP_W-1:SEQ_W];
	assign chk_bound = chk_tl - SEQ_W'(WINDOW_BITS) + SEQ_W'(1);
	assign chk_ge    = lo_q >= chk_bound;

	always_comb begin
		if (chk_tl >= SEQ_W'(WINDOW_BITS - 1)) begin
			chk_hi = chk_ge ? chk_th : chk_th + SEQ_W'(1);
		end else begin
			chk_hi = chk_ge ? chk_th - SEQ_W'(1) : chk_th;
		end
	end

	assign chk_le  = {chk_hi, lo_q} <= top_q;
	assign chk_bit = rd_word[lo_q[OFF_W-1:0]];

	assign sweep_addr = (AW'(start_q >> OFF_W) + k_q[AW-1:0]) & AMASK;
	assign chk_addr   = AW'(seq_low[IDXW-1:0] >> OFF_W) & AMASK;

	always_comb begin
		logic [IDXW-1:0] idx_b;
		logic [IDXW-1:0] diff_b;
		clr_mask = '0;
		set_mask = '0;
		for (int b = 0; b < WORD_W; b++) begin
			idx_b       = IDXW'({wr_addr_s1, OFF_W'(b)});
			diff_b      = idx_b - start_q;
			clr_mask[b] = {1'b0, diff_b} < cnt_q;
			set_mask[b] = (idx_b == fidx);
		end
	end

	always_comb begin
		if (cmd.init_wr) begin
			ram_we    = 1'b1;
			ram_waddr = init_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_pend_s1;
			ram_waddr = wr_addr_s1;
			ram_wdata = (rd_word & ~clr_mask) | set_mask;
		end
		ram_re    = cmd.accept || cmd.sweep_rd;
		ram_raddr = cmd.sweep_rd ? sweep_addr : chk_addr;
	end

	ear_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_word)
	);

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			k_q         <= '0;
			init_q      <= '0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				init_q <= (init_q + AW'(1)) & AMASK;
			end
			wr_pend_s1 <= cmd.sweep_rd;
			if (cmd.prep) begin
				k_q <= '0;
				if (rec_gt) top_q <= rec_full;
			end else if (cmd.sweep_rd) begin
				k_q <= k_q + NWW'(1);
			end
			if (cmd.ld_chk || cmd.ld_rec) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lo_q    <= seq_low;
			hi_in_q <= seq_high;
		end
		if (cmd.prep) begin
			start_q  <= start_d;
			cnt_q    <= cnt_d;
			nwords_q <= nwords_d;
		end
		if (cmd.sweep_rd) begin
			wr_addr_s1 <= sweep_addr;
		end
		if (cmd.ld_chk) begin
			replay_q  <= chk_le && chk_bit;
			ihigh_q   <= chk_hi;
			top_out_q <= top_q;
		end else if (cmd.ld_rec) begin
			replay_q  <= 1'b0;
			ihigh_q   <= hi_in_q;
			top_out_q <= top_q;
		end
	end

	assign sts.init_last  = (init_q == AMASK);
	assign sts.sweep_last = (k_q == nwords_q - NWW'(1));
	assign sts.out_free   = out_free;

	assign rsp.valid         = out_valid_q;
	assign rsp.replay        = replay_q;
	assign rsp.inferred_high = ihigh_q;
	assign rsp.top_seq       = top_out_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_chk || cmd.ld_rec) |-> out_free)
		else $error("result loaded over an untaken transaction");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_rd |-> (k_q < nwords_q))
		else $error("ring sweep ran past its word count");

	a_top_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (top_q >= $past(top_q)))
		else $error("top sequence number moved backward");
endmodule

// File: hw/rtl/esn_anti_replay_window.sv
// Anti-replay window for 64-bit extended sequence numbers with a ring of seen bits.
// A check goes from idle through the check state, which holds while the output register is full;
// a record goes through prep, a sweep of N ring words (1 to WINDOW_BITS/32), drain and a result state.
// Results leave through an output register, so a finished result may wait while work goes on.
// After reset the top is zero and a clearing pass zeroes every ring word;
// no transaction is accepted during that pass. WINDOW_BITS must be a power of two.
module esn_anti_replay_window #(
	parameter int WINDOW_BITS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	ear_req_if.sink   req,
	ear_rsp_if.source rsp
);
	import ear_pkg::*;

	ear_cmd_t cmd;
	ear_sts_t sts;
	logic     in_ready;

	ear_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (action_t'(req.action)),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ear_dp #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.seq_low  (req.seq_low),
		.seq_high (req.seq_high),
		.rsp      (rsp)
	);

	assign req.ready = in_ready;
endmodule
